[design/gol_pkg.sv]
`timescale 1ns / 1ps

package gol_pkg;

	// Built grid size.
	localparam int GRID_W    = 64;
	localparam int GRID_H    = 64;
	localparam int COL_BITS  = 6;
	localparam int ROW_BITS  = 6;
	localparam int SIZE_BITS = 7;

	// Request modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_ADV   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_WRAP   = 2'd2;

	// Life rule.
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] SURVIVE_LOW = 4'd2;

	// Vertical window of one column: row above, the row being updated, row below.
	typedef struct packed {
		logic up;
		logic mid;
		logic dn;
	} gol_col_t;

	// One row-wide write into a bank.
	typedef struct packed {
		logic                en;
		logic [ROW_BITS-1:0] addr;
		logic [GRID_W-1:0]   data;
	} gol_wr_t;

	// A size of zero acts as one, a size above the built maximum acts as the maximum.
	function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
		input logic [SIZE_BITS-1:0] maxv);
		logic [SIZE_BITS-1:0] r;
		if (v == '0) begin
			r = SIZE_BITS'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[design/gol_bank.sv]
`timescale 1ns / 1ps

// One grid bank: one row per word, one write port, one registered read port.
// Per-row valid bits make an unwritten or cleared row read as all dead.
module gol_bank import gol_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  gol_wr_t             wr,
	input  logic [ROW_BITS-1:0] raddr,
	output logic [GRID_W-1:0]   rdata
);

	logic [GRID_W-1:0] mem [GRID_H];
	logic [GRID_H-1:0] row_vld_q;
	logic [GRID_W-1:0] rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (clr) begin
				row_vld_q <= '0;
			end else if (wr.en) begin
				row_vld_q[wr.addr] <= 1'b1;
			end
			rvld_q <= row_vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

[design/gol_cell.sv]
`timescale 1ns / 1ps

// One column of the automaton. It holds three vertically adjacent cells and
// shows them to both horizontal neighbors; each shift pulls a new row in below.
module gol_cell import gol_pkg::*; (
	input  logic     clk,
	input  logic     shift,
	input  logic     row_bit,
	input  gol_col_t left,
	input  gol_col_t right,
	input  logic     col_en,
	output gol_col_t col,
	output logic     next
);

	gol_col_t   win_q;
	logic [3:0] cnt;

	always_ff @(posedge clk) begin
		if (shift) begin
			win_q.up  <= win_q.mid;
			win_q.mid <= win_q.dn;
			win_q.dn  <= row_bit;
		end
	end

	assign col = win_q;

	always_comb begin
		cnt = 4'(left.up) + 4'(left.mid) + 4'(left.dn)
			+ 4'(right.up) + 4'(right.mid) + 4'(right.dn)
			+ 4'(win_q.up) + 4'(win_q.dn);
		next = col_en && ((cnt == BIRTH_COUNT) || (win_q.mid && (cnt == SURVIVE_LOW)));
	end

endmodule

[design/life_cellular_automaton_grid.sv]
`timescale 1ns / 1ps

// Game of Life (B3/S23) grid of up to 64 x 64 one-bit cells, held in two banks.
//
// Request channel: a request is taken on a rising edge with start high and busy
// low. mode 0 writes cell_in into (cell_row, cell_col), mode 1 reads that cell,
// mode 2 advances one generation, mode 3 does nothing. Every request gives one
// result: done is high for exactly one cycle with cell_out and status beside it.
// The receiver cannot stall, so results are never held back.
// Configuration channel: cfg_ready is always high; a write with cfg_valid sets
// grid_width (index 0), grid_height (index 1) or wrap_edges (index 2). The user must
// make writes only while no request is in flight; the block does not enforce this.
// An out-of-range coordinate or mode 3 gives done in the next cycle and
// never raises busy. A read or write is busy while the row is read from the
// bank and then for the bit select or read-modify-write, and done follows.
// In an advance, h the effective height, h + 2 row reads stream through the
// single read port of the source bank, one row per cycle,
// into a chain of 64 column cells; two pipeline stages later each new row is
// written to the other bank. Then the banks swap and done is raised.
// The read port of the source bank sets that rate.
// Reset: all cells dead (per-row valid bits are cleared at once, no sweep), bank a
// active, width 64, height 64, no wrap.
module life_cellular_automaton_grid import gol_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           mode,
	input  logic [ROW_BITS-1:0]  cell_row,
	input  logic [COL_BITS-1:0]  cell_col,
	input  logic                 cell_in,
	output logic                 done,
	output logic                 cell_out,
	output logic                 status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [SIZE_BITS-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_GEN  = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;

	// Configuration registers.
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic                 wrap_q;

	// Control.
	logic [2:0]           state_q;
	logic [SIZE_BITS-1:0] stp_q;
	logic                 active_q;
	logic                 done_q;
	logic                 cell_out_q;
	logic                 status_q;

	// Captured request.
	logic [1:0]           mode_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [COL_BITS-1:0]  col_q;
	logic                 in_q;

	// Advance pipeline: stage 1 has the row read, stage 2 writes the new row.
	logic                 vld_s1;
	logic                 blank_s1;
	logic [SIZE_BITS-1:0] stp_s1;
	logic                 wvld_s2;
	logic [ROW_BITS-1:0]  wrow_s2;

	logic [SIZE_BITS-1:0] w_eff;
	logic [SIZE_BITS-1:0] h_eff;
	logic [COL_BITS-1:0]  wm1;
	logic                 accept;
	logic                 oob_in;
	logic                 adv_go;
	logic [ROW_BITS-1:0]  gen_addr;
	logic                 gen_blank;
	logic [ROW_BITS-1:0]  raddr;
	logic [GRID_W-1:0]    rdata_a;
	logic [GRID_W-1:0]    rdata_b;
	logic [GRID_W-1:0]    src_rdata;
	logic [GRID_W-1:0]    rmw_data;
	logic [GRID_W-1:0]    row_in;
	logic [GRID_W-1:0]    next_vec;
	logic [GRID_W-1:0]    col_en;
	gol_wr_t              rmw_wr;
	gol_wr_t              gen_wr;
	gol_wr_t              wr_a;
	gol_wr_t              wr_b;
	gol_col_t             cols [GRID_W];
	gol_col_t             edge_left;
	gol_col_t             edge_right;

	assign w_eff  = clamp_size(width_q, SIZE_BITS'(GRID_W));
	assign h_eff  = clamp_size(height_q, SIZE_BITS'(GRID_H));
	assign wm1    = COL_BITS'(w_eff - SIZE_BITS'(1));

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign cell_out  = cell_out_q;
	assign status    = status_q;

	assign oob_in = ((mode == MODE_WRITE) || (mode == MODE_READ))
		&& (({1'b0, cell_row} >= h_eff) || ({1'b0, cell_col} >= w_eff));
	assign adv_go = accept && (mode == MODE_ADV);

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_BITS'(GRID_W);
			height_q <= SIZE_BITS'(GRID_H);
			wrap_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_WRAP:   wrap_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Row sequence of an advance: the row above row 0, rows 0 to h-1, then the row
	// below the last one. Without wrap the two border rows are forced dead; with
	// wrap they are rows h-1 and 0, which on a one-row torus is the row itself.
	always_comb begin
		gen_blank = 1'b0;
		if (stp_q == '0) begin
			gen_addr  = ROW_BITS'(h_eff - SIZE_BITS'(1));
			gen_blank = !wrap_q;
		end else if (stp_q == SIZE_BITS'(h_eff + SIZE_BITS'(1))) begin
			gen_addr  = '0;
			gen_blank = !wrap_q;
		end else begin
			gen_addr = ROW_BITS'(stp_q - SIZE_BITS'(1));
		end
	end

	assign raddr     = (state_q == ST_GEN) ? gen_addr : row_q;
	assign src_rdata = active_q ? rdata_b : rdata_a;

	// Read-modify-write of one row for a cell write.
	always_comb begin
		rmw_data        = src_rdata;
		rmw_data[col_q] = in_q;
	end

	assign rmw_wr.en   = (state_q == ST_ACC) && (mode_q == MODE_WRITE);
	assign rmw_wr.addr = row_q;
	assign rmw_wr.data = rmw_data;

	assign gen_wr.en   = wvld_s2;
	assign gen_wr.addr = wrow_s2;
	assign gen_wr.data = next_vec;

	// Cell writes go to the active bank, the new generation to the other one.
	assign wr_a = active_q ? gen_wr : rmw_wr;
	assign wr_b = active_q ? rmw_wr : gen_wr;

	// The destination is cleared as an advance starts, so rows past the
	// configured height read dead afterwards.
	gol_bank u_bank_a (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (adv_go && active_q),
		.wr     (wr_a),
		.raddr  (raddr),
		.rdata  (rdata_a)
	);

	gol_bank u_bank_b (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (adv_go && !active_q),
		.wr     (wr_b),
		.raddr  (raddr),
		.rdata  (rdata_b)
	);

	// Chain of column cells. Column 0 sees the last used column on its left under
	// wrap, and the last used column sees column 0 on its right; otherwise the
	// outside counts as dead. Columns past the configured width produce dead cells.
	assign row_in     = blank_s1 ? '0 : src_rdata;
	assign edge_left  = wrap_q ? cols[wm1] : '0;
	assign edge_right = wrap_q ? cols[0] : '0;

	for (genvar c = 0; c < GRID_W; c++) begin : g_cell
		gol_col_t lft;
		gol_col_t rgt;

		if (c == 0) begin : g_first
			assign lft = edge_left;
		end else begin : g_inner_l
			assign lft = cols[c-1];
		end

		if (c == GRID_W - 1) begin : g_last
			assign rgt = (wm1 == COL_BITS'(c)) ? edge_right : '0;
		end else begin : g_inner_r
			assign rgt = (wm1 == COL_BITS'(c)) ? edge_right : cols[c+1];
		end

		assign col_en[c] = (SIZE_BITS'(c) < w_eff);

		gol_cell u_cell (
			.clk     (clk),
			.shift   (vld_s1),
			.row_bit (row_in[c]),
			.left    (lft),
			.right   (rgt),
			.col_en  (col_en[c]),
			.col     (cols[c]),
			.next    (next_vec[c])
		);
	end

	// Request payload and pipeline data.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			row_q  <= cell_row;
			col_q  <= cell_col;
			in_q   <= cell_in;
		end
		blank_s1 <= gen_blank;
		stp_s1   <= stp_q;
		wrow_s2  <= ROW_BITS'(stp_s1 - SIZE_BITS'(2));
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stp_q      <= '0;
			active_q   <= 1'b0;
			done_q     <= 1'b0;
			cell_out_q <= 1'b0;
			status_q   <= 1'b0;
			vld_s1     <= 1'b0;
			wvld_s2    <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			vld_s1  <= (state_q == ST_GEN);
			wvld_s2 <= vld_s1 && (stp_s1 >= SIZE_BITS'(2));
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_ADV) begin
							stp_q   <= '0;
							state_q <= ST_GEN;
						end else if (((mode == MODE_WRITE) || (mode == MODE_READ)) && !oob_in) begin
							state_q <= ST_RD;
						end else begin
							// Out-of-range coordinate or unused mode: answer at once.
							done_q     <= 1'b1;
							status_q   <= oob_in;
							cell_out_q <= 1'b0;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					done_q     <= 1'b1;
					status_q   <= 1'b0;
					cell_out_q <= (mode_q == MODE_READ) ? src_rdata[col_q] : 1'b0;
					state_q    <= ST_IDLE;
				end
				ST_GEN: begin
					if (stp_q == SIZE_BITS'(h_eff + SIZE_BITS'(1))) begin
						state_q <= ST_WAIT;
					end else begin
						stp_q <= stp_q + SIZE_BITS'(1);
					end
				end
				ST_WAIT: begin
					if (!vld_s1 && !wvld_s2) begin
						active_q   <= !active_q;
						done_q     <= 1'b1;
						status_q   <= 1'b0;
						cell_out_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// New-generation rows are written only while an advance is in progress.
	a_gen_write_in_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wvld_s2 |-> ((state_q == ST_GEN) || (state_q == ST_WAIT)))
		else $error("generation row written outside an advance");

	// An accepted advance keeps the block busy.
	a_adv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == MODE_ADV)) |=> busy)
		else $error("advance accepted without going busy");

	// The banks swap only together with the result of an advance.
	a_swap_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q != $past(active_q)) |-> (done && !status && !cell_out))
		else $error("bank swap without advance result");

	// A flagged coordinate never returns a cell value.
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !cell_out)
		else $error("cell value returned with out-of-range status");

endmodule

[verif/life_cellular_automaton_grid_tb.sv]
`timescale 1ns / 1ps

// Testbench for the Game of Life grid. The testbench keeps its own copy of both
// cell banks, the bank select and the three size/wrap registers. Every request
// that the block takes is applied to that copy, and the result that the copy
// gives is queued. Each done pulse is checked against the oldest queued result.
module life_cellular_automaton_grid_tb;
	import gol_pkg::*;

	// Mode 3 has no name in the package; the block treats it as a no-op.
	localparam logic [1:0] MODE_NOP = 2'd3;

	// B3/S23: a dead cell with exactly three live neighbors is born, and a live
	// cell with two or three live neighbors survives.
	localparam int BIRTH_N  = 3;
	localparam int KEEP_MIN = 2;
	localparam int KEEP_MAX = 3;

	// A generous ceiling on the whole run still ends things if the block hangs.
	localparam int CYCLE_LIMIT = 500_000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 48;

	typedef struct packed {
		logic [1:0]          mode;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                val;
	} cell_req_t;

	typedef struct packed {
		logic cell_out;
		logic status;
	} cell_resp_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 done;
	logic                 cell_out;
	logic                 status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = CFG_WIDTH;
	logic [SIZE_BITS-1:0] cfg_data = '0;
	cell_req_t            drv_req = '0;

	// Our copy of the block's state. life_sel picks the bank that holds the
	// current generation; reg_* are the raw register values as written.
	logic [GRID_W-1:0]    life_bank [2][GRID_H];
	logic                 life_sel = 1'b0;
	logic [SIZE_BITS-1:0] reg_width = SIZE_BITS'(64);
	logic [SIZE_BITS-1:0] reg_height = SIZE_BITS'(64);
	logic                 reg_wrap = 1'b0;

	cell_req_t  pending_reqs [$];
	cell_resp_t expected_cells [$];
	int         mismatches = 0;
	int         cycle_count = 0;
	int         burst_left = 1;
	int         gap_left = 0;

	life_cellular_automaton_grid DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (drv_req.mode),
		.cell_row  (drv_req.row),
		.cell_col  (drv_req.col),
		.cell_in   (drv_req.val),
		.done      (done),
		.cell_out  (cell_out),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The size that is really used: zero acts as one, anything past the built
	// size acts as the built size.
	function automatic int grid_extent(input logic [SIZE_BITS-1:0] raw, input int lim);
		if (raw == '0)
			return 1;
		if (int'(raw) > lim)
			return lim;
		return int'(raw);
	endfunction

	// Applies one request to our copy of the grid and returns the result it gives.
	task automatic apply_grid_request(input cell_req_t q, output cell_resp_t r);
		int                w;
		int                h;
		int                rr;
		int                cc;
		int                n;
		logic [GRID_W-1:0] nxt;
		logic              alive;
		w = grid_extent(reg_width, GRID_W);
		h = grid_extent(reg_height, GRID_H);
		r = '0;
		case (q.mode)
			MODE_WRITE, MODE_READ: begin
				if (int'(q.row) >= h || int'(q.col) >= w) begin
					r.status = 1'b1;
				end else if (q.mode == MODE_WRITE) begin
					life_bank[life_sel][q.row][q.col] = q.val;
				end else begin
					r.cell_out = life_bank[life_sel][q.row][q.col];
				end
			end
			MODE_ADV: begin
				// Every row of the destination is rewritten, so cells outside
				// the configured grid come out dead.
				for (int row = 0; row < GRID_H; row++) begin
					nxt = '0;
					for (int col = 0; col < GRID_W; col++) begin
						if (row < h && col < w) begin
							n = 0;
							for (int dr = -1; dr <= 1; dr++) begin
								for (int dc = -1; dc <= 1; dc++) begin
									if (dr != 0 || dc != 0) begin
										rr = row + dr;
										cc = col + dc;
										// On a one-wide torus an offset can land on the
										// cell itself; it is counted once per offset.
										if (reg_wrap) begin
											rr = (rr + h) % h;
											cc = (cc + w) % w;
											n += life_bank[life_sel][ROW_BITS'(rr)][COL_BITS'(cc)];
										end else if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
											n += life_bank[life_sel][ROW_BITS'(rr)][COL_BITS'(cc)];
										end
									end
								end
							end
							alive = life_bank[life_sel][ROW_BITS'(row)][COL_BITS'(col)];
							if (alive)
								nxt[COL_BITS'(col)] = (n >= KEEP_MIN && n <= KEEP_MAX);
							else
								nxt[COL_BITS'(col)] = (n == BIRTH_N);
						end
					end
					life_bank[!life_sel][ROW_BITS'(row)] = nxt;
				end
				life_sel = !life_sel;
			end
			default: begin
				// No-op mode: nothing changes and the result is all zero.
			end
		endcase
	endtask

	// Driver. A request is taken at an edge with start high and busy low; at
	// that edge its result is predicted. The next request goes out in bursts of
	// random length, with random idle gaps between bursts.
	always @(posedge clk) begin
		cell_resp_t resp;
		logic       take;
		if (arst_n) begin
			take = start && !busy;
			if (take) begin
				apply_grid_request(drv_req, resp);
				expected_cells.push_back(resp);
			end
			if (take || !start) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					drv_req <= pending_reqs.pop_front();
					start <= 1'b1;
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						// Now and then a long burst, and now and then no gap at all.
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. The block cannot be held off, so every done pulse is a result.
	always @(posedge clk) begin
		cell_resp_t want;
		if (arst_n && done) begin
			if (expected_cells.size() == 0) begin
				$error("result with no request outstanding: cell_out %0b status %0b",
					cell_out, status);
				mismatches++;
			end else begin
				want = expected_cells.pop_front();
				if (cell_out !== want.cell_out) begin
					$error("cell_out expected %0b actual %0b", want.cell_out, cell_out);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status expected %0b actual %0b", want.status, status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("life_cellular_automaton_grid regression: fail");
			$finish;
		end
	end

	function automatic void queue_req(input logic [1:0] m, input int row, input int col,
		input logic val);
		cell_req_t q;
		q.mode = m;
		q.row  = ROW_BITS'(row);
		q.col  = COL_BITS'(col);
		q.val  = val;
		pending_reqs.push_back(q);
	endfunction

	// Waits until every queued request was taken and answered, then lets the
	// clock run on so the block is surely idle. Checked on the falling edge,
	// where nothing is changing.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_cells.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// One register write on the configuration channel, taken at an edge with
	// valid and ready both high. Our copy of the register follows at that edge.
	task automatic write_reg(input logic [1:0] idx, input logic [SIZE_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_WIDTH:  reg_width = val;
			CFG_HEIGHT: reg_height = val;
			CFG_WRAP:   reg_wrap = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Grid sizes lean small so generations stay busy, with the extremes mixed in.
	function automatic logic [SIZE_BITS-1:0] pick_size();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return SIZE_BITS'(0);
			1: return SIZE_BITS'(1);
			2: return SIZE_BITS'(2);
			3: return SIZE_BITS'(3);
			4: return SIZE_BITS'(64);
			5: return SIZE_BITS'($urandom_range(65, 127));
			9: return SIZE_BITS'($urandom_range(1, 64));
			default: return SIZE_BITS'($urandom_range(4, 10));
		endcase
	endfunction

	initial begin
		int            w;
		int            h;
		int            seeds;
		int            sel;
		int            row;
		int            col;
		logic [1:0]    m;
		logic          val;
		for (int r = 0; r < GRID_H; r++) begin
			life_bank[0][ROW_BITS'(r)] = '0;
			life_bank[1][ROW_BITS'(r)] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on the reset configuration: 64 x 64, no wrap. Corners,
		// the no-op mode, a birth in the corner and a blinker in the middle.
		queue_req(MODE_READ, 0, 0, 1'b1);
		queue_req(MODE_WRITE, 0, 0, 1'b1);
		queue_req(MODE_READ, 0, 0, 1'b0);
		queue_req(MODE_WRITE, 63, 63, 1'b1);
		queue_req(MODE_READ, 63, 63, 1'b0);
		queue_req(MODE_READ, 63, 0, 1'b1);
		queue_req(MODE_NOP, 63, 63, 1'b1);
		queue_req(MODE_WRITE, 0, 1, 1'b1);
		queue_req(MODE_WRITE, 1, 0, 1'b1);
		queue_req(MODE_WRITE, 31, 20, 1'b1);
		queue_req(MODE_WRITE, 31, 21, 1'b1);
		queue_req(MODE_WRITE, 31, 22, 1'b1);
		queue_req(MODE_ADV, 0, 0, 1'b0);
		queue_req(MODE_READ, 1, 1, 1'b0);
		queue_req(MODE_READ, 30, 21, 1'b0);
		queue_req(MODE_READ, 31, 20, 1'b0);
		queue_req(MODE_WRITE, 63, 63, 1'b0);
		queue_req(MODE_ADV, 63, 63, 1'b1);
		queue_req(MODE_READ, 0, 0, 1'b0);
		wait_idle();

		// A size of zero acts as one: a 1 x 1 torus, where the single cell sees
		// itself through all eight offsets and so dies. Coordinates past the
		// single cell are flagged and change nothing.
		write_reg(CFG_WIDTH, SIZE_BITS'(0));
		write_reg(CFG_HEIGHT, SIZE_BITS'(0));
		write_reg(CFG_WRAP, SIZE_BITS'(1));
		queue_req(MODE_WRITE, 0, 0, 1'b1);
		queue_req(MODE_ADV, 0, 0, 1'b0);
		queue_req(MODE_READ, 0, 0, 1'b0);
		queue_req(MODE_WRITE, 0, 0, 1'b1);
		queue_req(MODE_READ, 0, 1, 1'b0);
		queue_req(MODE_WRITE, 1, 0, 1'b0);
		queue_req(MODE_READ, 0, 0, 1'b0);

		// Random phases. Each starts from an idle block with a new size and wrap
		// setting, seeds live cells into the grid, and then mixes writes, reads,
		// advances, no-ops and out-of-range coordinates. The grid carries over
		// from phase to phase, so cells left outside a smaller grid come back
		// into view when the grid grows.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			write_reg(CFG_WIDTH, (ph == 0) ? SIZE_BITS'(127) : pick_size());
			write_reg(CFG_HEIGHT, (ph == 0) ? SIZE_BITS'(65) : pick_size());
			write_reg(CFG_WRAP, SIZE_BITS'($urandom_range(0, 1)));
			w = grid_extent(reg_width, GRID_W);
			h = grid_extent(reg_height, GRID_H);
			seeds = (w * h / 2 < 12) ? w * h / 2 : 12;
			for (int k = 0; k < seeds; k++)
				queue_req(MODE_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1), 1'b1);
			for (int k = seeds; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(0, 99);
				row = $urandom_range(0, h - 1);
				col = $urandom_range(0, w - 1);
				val = ($urandom_range(0, 2) != 0);
				if (sel < 38) begin
					m = MODE_WRITE;
				end else if (sel < 68) begin
					m = MODE_READ;
				end else if (sel < 88) begin
					// The coordinate fields mean nothing here; fill them anyway.
					m = MODE_ADV;
					row = $urandom_range(0, 63);
					col = $urandom_range(0, 63);
				end else if (sel < 92) begin
					m = MODE_NOP;
					row = $urandom_range(0, 63);
					col = $urandom_range(0, 63);
				end else begin
					m = sel[0] ? MODE_READ : MODE_WRITE;
					if (h < GRID_H && (w == GRID_W || $urandom_range(0, 1) == 0)) begin
						row = $urandom_range(h, 63);
						col = $urandom_range(0, 63);
					end else if (w < GRID_W) begin
						row = $urandom_range(0, 63);
						col = $urandom_range(w, 63);
					end
				end
				queue_req(m, row, col, val);
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("life_cellular_automaton_grid regression: pass");
		else
			$display("life_cellular_automaton_grid regression: fail");
		$finish;
	end

endmodule
